[sv/ipv4l4_pkg.sv]
// shared constants and types for the ipv4 transport header parser
package ipv4l4_pkg;

    // frame layout
    localparam int ETH_HDR_BYTES  = 14;
    localparam int UDP_HDR_BYTES  = 8;
    localparam int TCP_MIN_BYTES  = 13;
    localparam int UDP_MIN_BYTES  = 4;
    localparam int IP_FIELDS_END  = 34;

    // byte positions of captured fields
    localparam logic [7:0] POS_ETYPE_HI = 8'd12;
    localparam logic [7:0] POS_ETYPE_LO = 8'd13;
    localparam logic [7:0] POS_IHL      = 8'd14;
    localparam logic [7:0] POS_TLEN_HI  = 8'd16;
    localparam logic [7:0] POS_TLEN_LO  = 8'd17;
    localparam logic [7:0] POS_PROTO    = 8'd23;
    localparam logic [7:0] POS_SRC_LO   = 8'd26;
    localparam logic [7:0] POS_SRC_HI   = 8'd29;
    localparam logic [7:0] POS_DST_LO   = 8'd30;
    localparam logic [7:0] POS_DST_HI   = 8'd33;
    localparam logic [7:0] POS_MAX      = 8'd255;

    // offsets inside the transport header
    localparam logic [7:0] REL_SPORT_HI = 8'd0;
    localparam logic [7:0] REL_SPORT_LO = 8'd1;
    localparam logic [7:0] REL_DPORT_HI = 8'd2;
    localparam logic [7:0] REL_DPORT_LO = 8'd3;
    localparam logic [7:0] REL_TCP_DOFF = 8'd12;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 120;
    localparam int OUT_TUSER_W = 4;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_IPV4  = 3'd1,
        ST_NOT_L4    = 3'd2,
        ST_LEN_SHORT = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

endpackage

[sv/ipv4_l4_header_parser.sv]
// ipv4 tcp/udp header parser: one frame byte per transfer in, one result per frame out
//
//  channel  | dir | tdata                          | tuser             | tlast
//  ---------+-----+--------------------------------+-------------------+------------
//  s_ frame | in  | [7:0] frame_byte               | -                 | frame_end
//  m_ result| out | src, dst, ports, start, length | status, is_tcp    | -
//
// one byte is taken every cycle while s_tready is high; header fields are captured as they pass.
// the result is formed in the same cycle as the final byte and held in the
// output register, visible in the cycle after the final byte is accepted.
// reset clears the captured fields, byte position and output valid.
// input is stalled only while a result waits and m_tready is low.
module ipv4_l4_header_parser (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ipv4l4_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] frame_byte
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [31:0] source_address, [63:32] destination_address, [79:64] source_port,
    // [95:80] destination_port, [103:96] payload_start, [119:104] payload_len
    output logic [ipv4l4_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // [2:0] status, [3] is_tcp
    output logic [ipv4l4_pkg::OUT_TUSER_W-1:0]    m_tuser
);
    import ipv4l4_pkg::*;

    // captured header state
    logic [7:0]  pos_reg,   pos_next;
    logic [15:0] etype_reg, etype_next, etype_upd;
    logic [3:0]  ihl_reg,   ihl_next,   ihl_upd;
    logic [7:0]  proto_reg, proto_next, proto_upd;
    logic [15:0] tlen_reg,  tlen_next,  tlen_upd;
    logic [31:0] src_reg,   src_next,   src_upd;
    logic [31:0] dst_reg,   dst_next,   dst_upd;
    logic [15:0] sport_reg, sport_next, sport_upd;
    logic [15:0] dport_reg, dport_next, dport_upd;
    logic [3:0]  doff_reg,  doff_next,  doff_upd;

    // output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg,  m_tuser_next;

    logic        accept;
    logic [7:0]  in_byte;
    logic [6:0]  l4_base;
    logic [7:0]  rel;
    logic        in_l4;
    logic [8:0]  count;
    logic [7:0]  need;
    logic        is_tcp;
    logic        is_udp;
    logic [6:0]  l4_bytes;
    logic [6:0]  offset;
    status_t     status;
    logic [7:0]  pay_start;
    logic [15:0] pay_len;
    logic        res_tcp;
    logic [31:0] res_src;
    logic [31:0] res_dst;
    logic [15:0] res_sport;
    logic [15:0] res_dport;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_byte  = s_tdata;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // field capture for the current byte
    always_comb begin
        etype_upd = etype_reg;
        ihl_upd   = ihl_reg;
        proto_upd = proto_reg;
        tlen_upd  = tlen_reg;
        src_upd   = src_reg;
        dst_upd   = dst_reg;
        sport_upd = sport_reg;
        dport_upd = dport_reg;
        doff_upd  = doff_reg;

        if (pos_reg == POS_ETYPE_HI) etype_upd = {in_byte, 8'h00};
        if (pos_reg == POS_ETYPE_LO) etype_upd = {etype_reg[15:8], in_byte};
        if (pos_reg == POS_IHL)      ihl_upd   = in_byte[3:0];
        if (pos_reg == POS_TLEN_HI)  tlen_upd  = {in_byte, 8'h00};
        if (pos_reg == POS_TLEN_LO)  tlen_upd  = {tlen_reg[15:8], in_byte};
        if (pos_reg == POS_PROTO)    proto_upd = in_byte;
        if (pos_reg >= POS_SRC_LO && pos_reg <= POS_SRC_HI)
            src_upd = {src_reg[23:0], in_byte};
        if (pos_reg >= POS_DST_LO && pos_reg <= POS_DST_HI)
            dst_upd = {dst_reg[23:0], in_byte};

        // transport header sits at 14 + ihl*4, with ihl as of this byte
        l4_base = 7'(ETH_HDR_BYTES) + {1'b0, ihl_upd, 2'b00};
        in_l4   = pos_reg >= {1'b0, l4_base};
        rel     = pos_reg - {1'b0, l4_base};
        if (in_l4) begin
            if (rel == REL_SPORT_HI) sport_upd = {in_byte, 8'h00};
            if (rel == REL_SPORT_LO) sport_upd = {sport_reg[15:8], in_byte};
            if (rel == REL_DPORT_HI) dport_upd = {in_byte, 8'h00};
            if (rel == REL_DPORT_LO) dport_upd = {dport_reg[15:8], in_byte};
            if (rel == REL_TCP_DOFF) doff_upd  = in_byte[7:4];
        end
    end

    // result for a frame ending on this byte
    always_comb begin
        count    = {1'b0, pos_reg} + 9'd1;
        is_tcp   = proto_upd == PROTO_TCP;
        is_udp   = proto_upd == PROTO_UDP;
        need     = {1'b0, l4_base} + (is_tcp ? 8'(TCP_MIN_BYTES) : 8'(UDP_MIN_BYTES));
        l4_bytes = is_tcp ? {1'b0, doff_upd, 2'b00} : 7'(UDP_HDR_BYTES);
        offset   = {1'b0, ihl_upd, 2'b00} + l4_bytes;

        status    = ST_OK;
        res_tcp   = 1'b0;
        res_src   = '0;
        res_dst   = '0;
        res_sport = '0;
        res_dport = '0;
        pay_start = '0;
        pay_len   = '0;

        if (count < 9'(ETH_HDR_BYTES)) begin
            status = ST_TRUNCATED;
        end else if (etype_upd != ETHERTYPE_IPV4) begin
            status = ST_NOT_IPV4;
        end else if (count < 9'(IP_FIELDS_END)) begin
            status = ST_TRUNCATED;
        end else if (!is_tcp && !is_udp) begin
            status  = ST_NOT_L4;
            res_src = src_upd;
            res_dst = dst_upd;
        end else if (count < {1'b0, need}) begin
            status = ST_TRUNCATED;
        end else begin
            res_tcp   = is_tcp;
            res_src   = src_upd;
            res_dst   = dst_upd;
            res_sport = sport_upd;
            res_dport = dport_upd;
            if (tlen_upd > {9'd0, offset}) begin
                status    = ST_OK;
                pay_start = 8'(ETH_HDR_BYTES) + {1'b0, offset};
                pay_len   = tlen_upd - {9'd0, offset};
            end else begin
                status = ST_LEN_SHORT;
            end
        end
    end

    // next state: advance on every transfer (saturating at 255), clear after the final byte
    always_comb begin
        pos_next   = pos_reg;
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        tlen_next  = tlen_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        doff_next  = doff_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (accept) begin
            if (s_tlast) begin
                pos_next   = '0;
                etype_next = '0;
                ihl_next   = '0;
                proto_next = '0;
                tlen_next  = '0;
                src_next   = '0;
                dst_next   = '0;
                sport_next = '0;
                dport_next = '0;
                doff_next  = '0;

                m_tvalid_next = 1'b1;
                m_tdata_next  = {pay_len, pay_start, res_dport, res_sport, res_dst, res_src};
                m_tuser_next  = {res_tcp, status};
            end else begin
                pos_next   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;
                etype_next = etype_upd;
                ihl_next   = ihl_upd;
                proto_next = proto_upd;
                tlen_next  = tlen_upd;
                src_next   = src_upd;
                dst_next   = dst_upd;
                sport_next = sport_upd;
                dport_next = dport_upd;
                doff_next  = doff_upd;
            end
        end
    end

    // control and captured state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            etype_reg    <= '0;
            ihl_reg      <= '0;
            proto_reg    <= '0;
            tlen_reg     <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            sport_reg    <= '0;
            dport_reg    <= '0;
            doff_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            etype_reg    <= etype_next;
            ihl_reg      <= ihl_next;
            proto_reg    <= proto_next;
            tlen_reg     <= tlen_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            sport_reg    <= sport_next;
            dport_reg    <= dport_next;
            doff_reg     <= doff_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

[verif/ipv4_l4_header_parser_tb.sv]
// self-checking testbench for the ipv4 tcp/udp header parser
module ipv4_l4_header_parser_tb;
    import ipv4l4_pkg::*;

    // one frame byte as it goes out on the input stream
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        status_t    typed_status;
    } wire_byte_t;

    // one parsed header result
    typedef struct packed {
        status_t     status;
        logic        is_tcp;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
        logic [7:0]  payload_start;
        logic [15:0] payload_len;
    } hdr_result_t;

    // one directed frame
    typedef struct {
        int          nbytes;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] tlen;
        logic [3:0]  doff;
        bit          typed;
        status_t     typed_status;
    } frame_row_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;   // [7:0] frame_byte
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;            // src, dst, sport, dport, start, length
    logic [3:0]   m_tuser;            // [2:0] status, [3] is_tcp

    wire_byte_t  wire_bytes_q[$];
    hdr_result_t expected_hdr_q[$];
    frame_row_t  dir_rows [21];
    int          fail_count = 0;
    int          cyc = 0;
    bit          s_taken = 1'b0;

    // header fields seen so far in the current frame
    int          frame_pos;
    logic [15:0] etype_seen;
    logic [3:0]  ihl_seen;
    logic [7:0]  proto_seen;
    logic [15:0] tlen_seen;
    logic [31:0] src_ip_seen;
    logic [31:0] dst_ip_seen;
    logic [15:0] sport_seen;
    logic [15:0] dport_seen;
    logic [3:0]  doff_seen;

    ipv4_l4_header_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_parse_state();
        frame_pos   = 0;
        etype_seen  = '0;
        ihl_seen    = '0;
        proto_seen  = '0;
        tlen_seen   = '0;
        src_ip_seen = '0;
        dst_ip_seen = '0;
        sport_seen  = '0;
        dport_seen  = '0;
        doff_seen   = '0;
    endfunction

    // capture one byte and, on the final one, work out the parsed header
    task automatic parse_header_byte(input logic [7:0] b, input logic fin,
                                     output bit got, output hdr_result_t r);
        int pos;
        int base;
        int rel;
        int count;
        int offset;
        bit tcp;
        pos = frame_pos;
        if (pos == POS_ETYPE_HI) etype_seen[15:8] = b;
        if (pos == POS_ETYPE_LO) etype_seen[7:0] = b;
        if (pos == POS_IHL) ihl_seen = b[3:0];
        if (pos == POS_TLEN_HI) tlen_seen[15:8] = b;
        if (pos == POS_TLEN_LO) tlen_seen[7:0] = b;
        if (pos == POS_PROTO) proto_seen = b;
        if (pos >= POS_SRC_LO && pos <= POS_SRC_HI) src_ip_seen = {src_ip_seen[23:0], b};
        if (pos >= POS_DST_LO && pos <= POS_DST_HI) dst_ip_seen = {dst_ip_seen[23:0], b};
        // transport header sits right after the ipv4 header, overlap or not
        base = ETH_HDR_BYTES + ihl_seen * 4;
        if (pos >= base) begin
            rel = pos - base;
            if (rel == REL_SPORT_HI) sport_seen[15:8] = b;
            if (rel == REL_SPORT_LO) sport_seen[7:0] = b;
            if (rel == REL_DPORT_HI) dport_seen[15:8] = b;
            if (rel == REL_DPORT_LO) dport_seen[7:0] = b;
            if (rel == REL_TCP_DOFF) doff_seen = b[7:4];
        end
        if (frame_pos < POS_MAX) frame_pos++;
        got = fin;
        r = '0;
        if (!fin) return;
        count = pos + 1;
        tcp = (proto_seen == PROTO_TCP);
        if (count < ETH_HDR_BYTES) begin
            r.status = ST_TRUNCATED;
        end else if (etype_seen != ETHERTYPE_IPV4) begin
            r.status = ST_NOT_IPV4;
        end else if (count < IP_FIELDS_END) begin
            r.status = ST_TRUNCATED;
        end else if (!tcp && proto_seen != PROTO_UDP) begin
            r.status = ST_NOT_L4;
            r.src_ip = src_ip_seen;
            r.dst_ip = dst_ip_seen;
        end else if (count < base + (tcp ? TCP_MIN_BYTES : UDP_MIN_BYTES)) begin
            r.status = ST_TRUNCATED;
        end else begin
            offset = ihl_seen * 4 + (tcp ? doff_seen * 4 : UDP_HDR_BYTES);
            r.is_tcp      = tcp;
            r.src_ip      = src_ip_seen;
            r.dst_ip      = dst_ip_seen;
            r.src_l4_port = sport_seen;
            r.dst_l4_port = dport_seen;
            if (tlen_seen > offset) begin
                r.status        = ST_OK;
                r.payload_start = 8'(ETH_HDR_BYTES + offset);
                r.payload_len   = 16'(tlen_seen - offset);
            end else begin
                r.status = ST_LEN_SHORT;
            end
        end
        clear_parse_state();
    endtask

    // build a frame with random filler and the given header fields
    task automatic queue_frame(input int nbytes, input logic [15:0] etype,
                               input logic [3:0] ihl, input logic [7:0] proto,
                               input logic [15:0] tlen, input logic [3:0] doff,
                               input bit typed, input status_t st);
        logic [7:0] fb [0:511];
        wire_byte_t w;
        int base;
        for (int i = 0; i < 512; i++) fb[i] = 8'($urandom);
        fb[POS_ETYPE_HI] = etype[15:8];
        fb[POS_ETYPE_LO] = etype[7:0];
        fb[POS_IHL]      = {fb[POS_IHL][7:4], ihl};
        fb[POS_TLEN_HI]  = tlen[15:8];
        fb[POS_TLEN_LO]  = tlen[7:0];
        fb[POS_PROTO]    = proto;
        base = ETH_HDR_BYTES + ihl * 4 + REL_TCP_DOFF;
        fb[base] = {doff, fb[base][3:0]};
        for (int i = 0; i < nbytes; i++) begin
            w.data         = fb[i];
            w.last         = (i == nbytes - 1);
            w.typed        = typed;
            w.typed_status = st;
            wire_bytes_q.push_back(w);
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0h, actual %0h", name, want, seen);
            fail_count++;
        end
    endfunction

    // drive the input side and the result ready at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_taken) begin
                // hold the pending transfer
            end else if (wire_bytes_q.size() > 0 &&
                         (cyc >= 500 && cyc < 1000 || $urandom_range(99) >= 14)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= wire_bytes_q[0].data;
                s_tlast  <= wire_bytes_q[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= (cyc >= 500 && cyc < 1000) || ($urandom_range(99) >= 14);
        end
    end

    // sample transfers at the rising edge: predict on input, compare on output
    wire_byte_t  took_byte;
    hdr_result_t predicted;
    hdr_result_t want;
    bit          has_result;

    always @(posedge aclk) begin
        if (aresetn) begin
            cyc++;
            s_taken = s_tvalid && s_tready;
            if (s_taken) begin
                took_byte = wire_bytes_q.pop_front();
                parse_header_byte(took_byte.data, took_byte.last, has_result, predicted);
                if (has_result) begin
                    if (took_byte.typed) begin
                        predicted = '0;
                        predicted.status = took_byte.typed_status;
                    end
                    expected_hdr_q.push_back(predicted);
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_hdr_q.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    fail_count++;
                end else begin
                    want = expected_hdr_q.pop_front();
                    check_field("status", want.status, m_tuser[2:0]);
                    check_field("is_tcp", want.is_tcp, m_tuser[3]);
                    check_field("source_address", want.src_ip, m_tdata[31:0]);
                    check_field("destination_address", want.dst_ip, m_tdata[63:32]);
                    check_field("source_port", want.src_l4_port, m_tdata[79:64]);
                    check_field("destination_port", want.dst_l4_port, m_tdata[95:80]);
                    check_field("payload_start", want.payload_start, m_tdata[103:96]);
                    check_field("payload_len", want.payload_len, m_tdata[119:104]);
                end
            end
        end
    end

    // main sequence
    int          total;
    int          n;
    int          hdr;
    int          need;
    int          k;
    bit          tcp_pick;
    logic [3:0]  ihl_r;
    logic [3:0]  doff_r;
    logic [7:0]  proto_r;
    logic [15:0] tlen_r;

    initial begin
        clear_parse_state();
        // directed frames: nbytes, ethertype, ihl, protocol, total length, data offset, typed flag, typed status
        dir_rows = '{
            '{1,   16'h0800, 4'd5,  PROTO_UDP, 16'd100,   4'd5,  1, ST_TRUNCATED},
            '{13,  16'h0800, 4'd5,  PROTO_UDP, 16'd100,   4'd5,  1, ST_TRUNCATED},
            '{14,  16'h86dd, 4'd5,  PROTO_TCP, 16'd100,   4'd5,  1, ST_NOT_IPV4},
            '{14,  16'h0000, 4'd5,  PROTO_TCP, 16'd100,   4'd5,  1, ST_NOT_IPV4},
            '{60,  16'hffff, 4'd5,  PROTO_UDP, 16'd100,   4'd5,  1, ST_NOT_IPV4},
            '{14,  16'h0800, 4'd5,  PROTO_UDP, 16'd100,   4'd5,  1, ST_TRUNCATED},
            '{33,  16'h0800, 4'd5,  PROTO_UDP, 16'd100,   4'd5,  1, ST_TRUNCATED},
            '{34,  16'h0800, 4'd5,  8'd0,      16'd100,   4'd5,  0, ST_OK},
            '{40,  16'h0800, 4'd5,  8'd255,    16'd100,   4'd5,  0, ST_OK},
            '{37,  16'h0800, 4'd5,  PROTO_UDP, 16'd100,   4'd5,  1, ST_TRUNCATED},
            '{38,  16'h0800, 4'd5,  PROTO_UDP, 16'hffff,  4'd5,  0, ST_OK},
            '{42,  16'h0800, 4'd5,  PROTO_UDP, 16'd28,    4'd5,  0, ST_OK},
            '{42,  16'h0800, 4'd5,  PROTO_UDP, 16'd0,     4'd5,  0, ST_OK},
            '{46,  16'h0800, 4'd5,  PROTO_TCP, 16'd100,   4'd5,  1, ST_TRUNCATED},
            '{47,  16'h0800, 4'd5,  PROTO_TCP, 16'd41,    4'd5,  0, ST_OK},
            '{54,  16'h0800, 4'd5,  PROTO_TCP, 16'd40,    4'd5,  0, ST_OK},
            '{134, 16'h0800, 4'd15, PROTO_TCP, 16'hffff,  4'd15, 0, ST_OK},
            '{60,  16'h0800, 4'd0,  PROTO_UDP, 16'd300,   4'd5,  0, ST_OK},
            '{50,  16'h0800, 4'd1,  PROTO_TCP, 16'd21,    4'd0,  0, ST_OK},
            '{300, 16'h0800, 4'd5,  PROTO_UDP, 16'd500,   4'd5,  0, ST_OK},
            '{256, 16'h0800, 4'd5,  PROTO_TCP, 16'd1000,  4'd8,  0, ST_OK}
        };
        foreach (dir_rows[i])
            queue_frame(dir_rows[i].nbytes, dir_rows[i].etype, dir_rows[i].ihl,
                        dir_rows[i].proto, dir_rows[i].tlen, dir_rows[i].doff,
                        dir_rows[i].typed, dir_rows[i].typed_status);

        // random frames: mostly well formed tcp/udp, some noise and cut frames
        total = 0;
        while (total < 520) begin
            k = $urandom_range(99);
            if (k < 15) begin
                n = $urandom_range(60, 1);
                queue_frame(n, 16'($urandom), 4'($urandom), 8'($urandom),
                            16'($urandom), 4'($urandom), 0, ST_OK);
            end else begin
                tcp_pick = 1'($urandom_range(1));
                ihl_r    = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd5;
                doff_r   = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                    : 4'($urandom_range(15, 5));
                proto_r  = ($urandom_range(9) == 0) ? 8'($urandom)
                                                    : (tcp_pick ? PROTO_TCP : PROTO_UDP);
                hdr  = ihl_r * 4 + (tcp_pick ? doff_r * 4 : UDP_HDR_BYTES);
                need = ETH_HDR_BYTES + ihl_r * 4 + (tcp_pick ? TCP_MIN_BYTES : UDP_MIN_BYTES);
                n = ETH_HDR_BYTES + hdr;
                if (n < need) n = need;
                if (n < IP_FIELDS_END) n = IP_FIELDS_END;
                n += $urandom_range(16);
                k = $urandom_range(19);
                if (k == 0) n = $urandom_range(n - 1, 1);
                else if (k == 1) n = $urandom_range(300, 256);
                k = $urandom_range(9);
                if (k < 7)       tlen_r = 16'(hdr + 1 + $urandom_range(64));
                else if (k == 7) tlen_r = 16'(hdr);
                else if (k == 8) tlen_r = 16'(hdr - $urandom_range(hdr));
                else             tlen_r = 16'($urandom);
                queue_frame(n, ETHERTYPE_IPV4, ihl_r, proto_r, tlen_r, doff_r, 0, ST_OK);
            end
            total += n;
        end

        // reset, then let the stream run
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (wire_bytes_q.size() != 0 || expected_hdr_q.size() != 0);
        repeat (16) @(posedge aclk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
